[rtl/core/pvs_pkg.sv]
// Shared types, codes and the palette color table for the packed video store scanout.
// Standalone package; used by packed_vram_palette_scanout.
`timescale 1ns / 1ps

package pvs_pkg;

	localparam int LINE_WIDTH     = 128;
	localparam int BYTES_PER_LINE = LINE_WIDTH / 4;
	localparam int GRP_W          = $clog2(BYTES_PER_LINE);
	localparam logic [GRP_W-1:0] GRP_LAST = GRP_W'(BYTES_PER_LINE - 1);

	typedef logic [15:0] rgb565_t;

	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_RENDER = 2'd1,
		ACT_FORCE  = 2'd2,
		ACT_QUERY  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_GROUP  = 2'd1,
		KIND_CLEAN  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_PAL_RD,
		ST_PAL_CAP,
		ST_STREAM,
		ST_DRAIN
	} state_t;

	localparam rgb565_t COLOR_TABLE [4][4] = '{
		'{16'h066B, 16'hF98A, 16'h49FE, 16'h97F4},
		'{16'h066B, 16'hF98A, 16'h49FE, 16'hE71C},
		'{16'h066B, 16'hF98A, 16'h49FE, 16'hCE9F},
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}
	};

	function automatic rgb565_t pal_color(logic [1:0] pal, logic [1:0] pix);
		return COLOR_TABLE[pal][pix];
	endfunction

endpackage

[rtl/core/pvs_vram.sv]
// Byte-wide video store: one write port, one read port with registered read data.
// Standalone; instantiated by packed_vram_palette_scanout.
`timescale 1ns / 1ps

module pvs_vram #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/packed_vram_palette_scanout.sv]
// Write: read-back (ST_WR_RD), then merged write-back (ST_WR_WB). Force, query and clean
// line render are handled in ST_IDLE. Dirty line render: palette read and capture, then
// one color group per cycle while the output is not stalled, then the next item.
// All store traffic goes through the single read and write port of the video store.
// Reset: control state clears at once, then a clearing pass zeroes all LINE_COUNT*32
// bytes of the store (2048 by default), one byte per cycle, input stalled.
`timescale 1ns / 1ps

module packed_vram_palette_scanout
	import pvs_pkg::*;
#(
	parameter int LINE_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [6:0]  column,
	input  logic [5:0]  row,
	input  logic [1:0]  pixel_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic        frame_dirty,
	output logic [12:0] pixel_index,
	output logic [15:0] color_first,
	output logic [15:0] color_second,
	output logic [15:0] color_third,
	output logic [15:0] color_fourth,
	output logic        last
);

	localparam int STORE_BYTES = LINE_COUNT * BYTES_PER_LINE;
	localparam int ROW_W       = $clog2(LINE_COUNT);
	localparam int AW          = ROW_W + GRP_W;

	state_t           state_q, state_d;
	logic [AW-1:0]    clr_q;
	logic [5:0]       row_q;
	logic [6:0]       col_q;
	logic [1:0]       val_q;
	logic [1:0]       pal_q;
	logic [GRP_W-1:0] grp_q;
	logic [GRP_W-1:0] grp_s1;
	logic             vld_s1;
	logic [LINE_COUNT-1:0] dirty_q;
	logic             frame_q;

	logic             out_valid_q;
	kind_t            kind_q;
	logic             frame_dirty_q;
	logic [12:0]      pixel_index_q;
	rgb565_t          color_first_q, color_second_q, color_third_q, color_fourth_q;
	logic             last_q;

	action_t          act;
	logic             accept;
	logic             row_ok;
	logic [ROW_W-1:0] in_row_idx;
	logic [ROW_W-1:0] row_idx_q;
	logic             out_busy;
	logic             out_load;
	logic             single_load;
	kind_t            single_kind;
	logic             issue;
	logic             line_done;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [7:0]       mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [7:0]       rd_data;
	logic [7:0]       merged;

	pvs_vram #(
		.DEPTH(STORE_BYTES),
		.AW   (AW)
	) u_vram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rd_data)
	);

	assign act        = action_t'(action);
	assign row_ok     = int'(row) < LINE_COUNT;
	assign in_row_idx = ROW_W'(row);
	assign row_idx_q  = ROW_W'(row_q);
	assign out_busy   = out_valid_q && out_stall;
	assign out_load   = vld_s1 && !out_busy;
	assign accept     = in_valid && !in_stall;
	assign line_done  = (state_q == ST_DRAIN) && out_load && (grp_s1 == GRP_LAST);

	// insert the new pixel into the byte read back from the store
	always_comb begin
		unique case (col_q[1:0])
			2'd0: merged = {val_q, rd_data[5:0]};
			2'd1: merged = {rd_data[7:6], val_q, rd_data[3:0]};
			2'd2: merged = {rd_data[7:4], val_q, rd_data[1:0]};
			2'd3: merged = {rd_data[7:2], val_q};
			default: merged = rd_data;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		mem_we      = 1'b0;
		mem_waddr   = clr_q;
		mem_wdata   = 8'd0;
		mem_re      = 1'b0;
		mem_raddr   = {row_idx_q, grp_q};
		issue       = 1'b0;
		single_load = 1'b0;
		single_kind = KIND_STATUS;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == AW'(STORE_BYTES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = out_busy && (act == ACT_QUERY || act == ACT_RENDER);
				if (in_valid && !in_stall) begin
					unique case (act)
						ACT_WRITE: begin
							if (row_ok) begin
								state_d = ST_WR_RD;
							end
						end
						ACT_RENDER: begin
							if (row_ok && dirty_q[in_row_idx]) begin
								state_d = ST_PAL_RD;
							end else begin
								single_load = 1'b1;
								single_kind = KIND_CLEAN;
							end
						end
						ACT_FORCE: begin
						end
						ACT_QUERY: begin
							single_load = 1'b1;
							single_kind = KIND_STATUS;
						end
						default: begin
						end
					endcase
				end
			end
			ST_WR_RD: begin
				mem_re    = 1'b1;
				mem_raddr = {row_idx_q, col_q[6:2]};
				state_d   = ST_WR_WB;
			end
			ST_WR_WB: begin
				mem_we    = 1'b1;
				mem_waddr = {row_idx_q, col_q[6:2]};
				mem_wdata = merged;
				state_d   = ST_IDLE;
			end
			ST_PAL_RD: begin
				// the byte holding columns 124..127 selects the palette row
				mem_re    = 1'b1;
				mem_raddr = {row_idx_q, GRP_LAST};
				state_d   = ST_PAL_CAP;
			end
			ST_PAL_CAP: begin
				state_d = ST_STREAM;
			end
			ST_STREAM: begin
				if (!vld_s1 || out_load) begin
					issue  = 1'b1;
					mem_re = 1'b1;
					if (grp_q == GRP_LAST) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (line_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			grp_q   <= '0;
			grp_s1  <= '0;
			vld_s1  <= 1'b0;
			dirty_q <= '0;
			frame_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_PAL_CAP) begin
				grp_q <= '0;
			end else if (issue) begin
				grp_q <= grp_q + 1'b1;
			end
			if (issue) begin
				vld_s1 <= 1'b1;
				grp_s1 <= grp_q;
			end else if (out_load) begin
				vld_s1 <= 1'b0;
			end
			if (accept && act == ACT_WRITE && row_ok) begin
				dirty_q[in_row_idx] <= 1'b1;
				frame_q             <= 1'b1;
			end else if (accept && act == ACT_FORCE) begin
				dirty_q <= '1;
				frame_q <= 1'b1;
			end else if (line_done) begin
				dirty_q[row_idx_q] <= 1'b0;
				if (int'(row_q) == LINE_COUNT - 1) begin
					frame_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= row;
			col_q <= column;
			val_q <= pixel_value;
		end
		if (state_q == ST_PAL_CAP) begin
			pal_q <= {rd_data[3], rd_data[5]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load || single_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q         <= KIND_GROUP;
			frame_dirty_q  <= 1'b0;
			pixel_index_q  <= {row_q, grp_s1, 2'b00};
			color_first_q  <= pal_color(pal_q, rd_data[7:6]);
			color_second_q <= pal_color(pal_q, rd_data[5:4]);
			color_third_q  <= pal_color(pal_q, rd_data[3:2]);
			color_fourth_q <= pal_color(pal_q, rd_data[1:0]);
			last_q         <= (grp_s1 == GRP_LAST);
		end else if (single_load) begin
			kind_q         <= single_kind;
			frame_dirty_q  <= (single_kind == KIND_STATUS) ? frame_q : 1'b0;
			pixel_index_q  <= '0;
			color_first_q  <= '0;
			color_second_q <= '0;
			color_third_q  <= '0;
			color_fourth_q <= '0;
			last_q         <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign frame_dirty  = frame_dirty_q;
	assign pixel_index  = pixel_index_q;
	assign color_first  = color_first_q;
	assign color_second = color_second_q;
	assign color_third  = color_third_q;
	assign color_fourth = color_fourth_q;
	assign last         = last_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load || single_load) |-> !out_busy)
		else $error("result register reloaded while stalled");

	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> in_stall)
		else $error("item accepted during clearing pass");

	a_mark_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		line_done |=> !dirty_q[$past(row_idx_q)])
		else $error("line mark not cleared after render");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_WR_WB))
		else $error("store written outside clear or write-back");

	a_stage_states: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_STREAM || state_q == ST_DRAIN))
		else $error("read stage valid outside line streaming");
`endif

endmodule
